// ===== rtl/core/cds_pkg.sv =====
// Package for the calendar date stepper: opcodes, year limits, the
// controller/datapath command and status structs, and calendar helper functions.
// No dependencies.
`timescale 1ns / 1ps

package cds_pkg;

  typedef enum logic [2:0] {
    OP_LOAD       = 3'd0,
    OP_ADD_DAYS   = 3'd1,
    OP_SUB_DAYS   = 3'd2,
    OP_ADD_MONTHS = 3'd3,
    OP_SUB_MONTHS = 3'd4,
    OP_ADD_YEARS  = 3'd5,
    OP_SUB_YEARS  = 3'd6,
    OP_QUERY      = 3'd7
  } op_t;

  localparam logic [13:0] YEAR_MIN  = 14'd1;
  localparam logic [13:0] YEAR_MAX  = 14'd9999;
  localparam logic [13:0] RST_YEAR  = 14'd2000;
  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_DEC = 4'd12;
  localparam logic [4:0]  DAY_FIRST = 5'd1;
  localparam logic [4:0]  DAY_MAX   = 5'd31;
  // floor(2^19 / 100) + 1: exact quotient by 100 for any year below 12800 (7-bit result)
  localparam logic [12:0] RECIP_100 = 13'd5243;

  typedef struct packed {
    logic start;   // capture the accepted command
    logic step;    // one iteration of the command
    logic commit;  // write the work date back unless refused
    logic wday;    // register the century quotient for the weekday
    logic emit;    // load the result register
  } cmd_t;

  typedef struct packed {
    logic done;    // command finished or refused
  } sts_t;

  // Quotient of a 14-bit year by 100
  function automatic logic [6:0] div100(input logic [13:0] y);
    logic [26:0] prod;
    prod = 27'(y) * 27'(RECIP_100);
    return prod[25:19];
  endfunction

  function automatic logic is_leap(input logic [13:0] y);
    logic [6:0]  q;
    logic [13:0] back;
    q    = div100(y);
    back = 14'({q, 6'b0}) + 14'({q, 5'b0}) + 14'({q, 2'b0});
    // divisible by 100 only counts as leap when also divisible by 400
    return (y[1:0] == 2'b00) && ((back != y) || (q[1:0] == 2'b00));
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    logic [4:0] len;
    case (m) inside
      4'd2:                   len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = DAY_MAX;
    endcase
    return len;
  endfunction

  // floor(31 * mm / 12) with March as month one of the shifted year
  function automatic logic [4:0] month_offset(input logic [3:0] m);
    logic [4:0] t;
    case (m)
      4'd1:    t = 5'd28;
      4'd2:    t = 5'd31;
      4'd3:    t = 5'd2;
      4'd4:    t = 5'd5;
      4'd5:    t = 5'd7;
      4'd6:    t = 5'd10;
      4'd7:    t = 5'd12;
      4'd8:    t = 5'd15;
      4'd9:    t = 5'd18;
      4'd10:   t = 5'd20;
      4'd11:   t = 5'd23;
      4'd12:   t = 5'd25;
      default: t = 5'd0;
    endcase
    return t;
  endfunction

  // 8 = 1 mod 7: fold octal digits, then one correction
  function automatic logic [2:0] mod7(input logic [14:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12]);
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[2:0];
  endfunction

endpackage

// ===== rtl/core/calendar_date_stepper.sv =====
// Top level of the calendar date stepper: joins the controller and datapath.
// Depends on cds_pkg, cds_ctrl and cds_dpath.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  opcode, step_count, load_year/month/day
//   out_     output     out_valid/out_stall cur_year/month/day, weekday, range_error
//
// One command at a time. Day and month moves iterate one day or one month per
// cycle and stop early when a command is refused.
// Reset restores 2000-01-01 and empties the result register.
// A stalled result holds in its register; one more command is taken and waits
// at the result stage, stalling the input, until the register frees.
`timescale 1ns / 1ps

module calendar_date_stepper (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [14:0] in_step_count,
  input  logic [13:0] in_load_year,
  input  logic [3:0]  in_load_month,
  input  logic [4:0]  in_load_day,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] out_cur_year,
  output logic [3:0]  out_cur_month,
  output logic [4:0]  out_cur_day,
  output logic [2:0]  out_weekday,
  output logic        out_range_error
);
  import cds_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cds_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_opcode),
    .in_step_count   (in_step_count),
    .in_load_year    (in_load_year),
    .in_load_month   (in_load_month),
    .in_load_day     (in_load_day),
    .out_cur_year    (out_cur_year),
    .out_cur_month   (out_cur_month),
    .out_cur_day     (out_cur_day),
    .out_weekday     (out_weekday),
    .out_range_error (out_range_error)
  );

endmodule

// ===== rtl/core/cds_ctrl.sv =====
// Controller of the calendar date stepper: sequences capture, iteration,
// commit, weekday and result transfer. Depends on cds_pkg.
`timescale 1ns / 1ps

module cds_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  cds_pkg::sts_t  sts,
  output cds_pkg::cmd_t  cmd
);
  import cds_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_COMMIT = 5'b00100,
    S_WDAY   = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.done) begin
          state_nxt = S_COMMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_WDAY;
      end
      S_WDAY: begin
        cmd.wday  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the result register can take a new transfer
        if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/cds_dpath.sv =====
// Datapath of the calendar date stepper: held date, work date, step counter,
// one-day / one-month iteration, year moves, weekday and result register.
// Depends on cds_pkg.
`timescale 1ns / 1ps

module cds_dpath (
  input  logic           clk,
  input  logic           rst_n,
  input  cds_pkg::cmd_t  cmd,
  output cds_pkg::sts_t  sts,
  input  logic [2:0]     in_opcode,
  input  logic [14:0]    in_step_count,
  input  logic [13:0]    in_load_year,
  input  logic [3:0]     in_load_month,
  input  logic [4:0]     in_load_day,
  output logic [13:0]    out_cur_year,
  output logic [3:0]     out_cur_month,
  output logic [4:0]     out_cur_day,
  output logic [2:0]     out_weekday,
  output logic           out_range_error
);
  import cds_pkg::*;

  // held date
  logic [13:0] held_year_r;
  logic [3:0]  held_month_r;
  logic [4:0]  held_day_r;

  // captured command
  op_t         op_r;
  logic [14:0] n_r;
  logic [13:0] ly_r;
  logic [3:0]  lm_r;
  logic [4:0]  ld_r;

  // work date and iteration state
  logic [13:0] wy_r, wy_nxt;
  logic [3:0]  wm_r, wm_nxt;
  logic [4:0]  wd_r, wd_nxt;
  logic [14:0] cnt_r;
  logic        err_r, err_nxt;
  logic [14:0] cnt_init;

  // weekday
  logic [6:0]  q_r;
  logic [13:0] yy;
  logic [14:0] wsum;

  // output register
  logic [13:0] o_year_r;
  logic [3:0]  o_month_r;
  logic [4:0]  o_day_r;
  logic [2:0]  o_wday_r;
  logic        o_err_r;

  logic        lp;
  logic [3:0]  pm, nm;
  logic [4:0]  ml, pml, nml;
  logic [15:0] ysum;
  op_t         in_op;

  assign in_op = op_t'(in_opcode);

  always_comb begin
    case (in_op) inside
      OP_ADD_DAYS, OP_SUB_DAYS, OP_ADD_MONTHS, OP_SUB_MONTHS: cnt_init = in_step_count;
      // capture/check step, then day clamp step
      OP_LOAD, OP_ADD_YEARS, OP_SUB_YEARS:                    cnt_init = 15'd2;
      default:                                                cnt_init = 15'd0;
    endcase
  end

  assign sts.done = (cnt_r == 15'd0) || err_r;

  assign lp   = is_leap(wy_r);
  assign pm   = wm_r - 4'd1;
  assign nm   = wm_r + 4'd1;
  assign ml   = month_len(lp, wm_r);
  assign pml  = month_len(lp, pm);
  assign nml  = month_len(lp, nm);
  assign ysum = 16'(wy_r) + 16'(n_r);

  always_comb begin
    wy_nxt  = wy_r;
    wm_nxt  = wm_r;
    wd_nxt  = wd_r;
    err_nxt = err_r;
    case (op_r)
      OP_ADD_DAYS: begin
        if (wd_r >= ml) begin
          wd_nxt = DAY_FIRST;
          if (wm_r == MONTH_DEC) begin
            if (wy_r >= YEAR_MAX) begin
              err_nxt = 1'b1;
            end else begin
              wm_nxt = MONTH_JAN;
              wy_nxt = wy_r + 14'd1;
            end
          end else begin
            wm_nxt = nm;
          end
        end else begin
          wd_nxt = wd_r + 5'd1;
        end
      end
      OP_SUB_DAYS: begin
        if (wd_r <= DAY_FIRST) begin
          if (wm_r == MONTH_JAN) begin
            if (wy_r <= YEAR_MIN) begin
              err_nxt = 1'b1;
            end else begin
              wy_nxt = wy_r - 14'd1;
              wm_nxt = MONTH_DEC;
              wd_nxt = DAY_MAX;
            end
          end else begin
            wm_nxt = pm;
            wd_nxt = pml;
          end
        end else begin
          wd_nxt = wd_r - 5'd1;
        end
      end
      OP_ADD_MONTHS: begin
        if (wm_r == MONTH_DEC) begin
          if (wy_r >= YEAR_MAX) begin
            err_nxt = 1'b1;
          end else begin
            wm_nxt = MONTH_JAN;
            wy_nxt = wy_r + 14'd1;
          end
        end else begin
          wm_nxt = nm;
          if (wd_r > nml) wd_nxt = nml;
        end
      end
      OP_SUB_MONTHS: begin
        if (wm_r == MONTH_JAN) begin
          if (wy_r <= YEAR_MIN) begin
            err_nxt = 1'b1;
          end else begin
            wm_nxt = MONTH_DEC;
            wy_nxt = wy_r - 14'd1;
          end
        end else begin
          wm_nxt = pm;
          if (wd_r > pml) wd_nxt = pml;
        end
      end
      OP_LOAD: begin
        if (cnt_r[1]) begin
          if ((ly_r < YEAR_MIN) || (ly_r > YEAR_MAX)) begin
            err_nxt = 1'b1;
          end else begin
            wy_nxt = ly_r;
            if (lm_r < MONTH_JAN) begin
              wm_nxt = MONTH_JAN;
            end else if (lm_r > MONTH_DEC) begin
              wm_nxt = MONTH_DEC;
            end else begin
              wm_nxt = lm_r;
            end
            wd_nxt = (ld_r < DAY_FIRST) ? DAY_FIRST : ld_r;
          end
        end else if (wd_r > ml) begin
          wd_nxt = ml;
        end
      end
      OP_ADD_YEARS: begin
        if (cnt_r[1]) begin
          if (ysum > 16'(YEAR_MAX)) begin
            err_nxt = 1'b1;
          end else begin
            wy_nxt = ysum[13:0];
          end
        end else if (wd_r > ml) begin
          wd_nxt = ml;
        end
      end
      OP_SUB_YEARS: begin
        if (cnt_r[1]) begin
          // n below the year also keeps the result at or above the minimum
          if (n_r >= 15'(wy_r)) begin
            err_nxt = 1'b1;
          end else begin
            wy_nxt = wy_r - n_r[13:0];
          end
        end else if (wd_r > ml) begin
          wd_nxt = ml;
        end
      end
      default: begin
      end
    endcase
  end

  // weekday of the held date
  assign yy   = held_year_r - ((held_month_r <= MONTH_FEB) ? 14'd1 : 14'd0);
  assign wsum = 15'(held_day_r) + 15'(yy) + 15'(yy[13:2]) - 15'(q_r) + 15'(q_r[6:2])
              + 15'(month_offset(held_month_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_year_r  <= RST_YEAR;
      held_month_r <= MONTH_JAN;
      held_day_r   <= DAY_FIRST;
      cnt_r        <= '0;
      err_r        <= 1'b0;
    end else begin
      if (cmd.start) begin
        cnt_r <= cnt_init;
        err_r <= 1'b0;
      end else if (cmd.step && !sts.done) begin
        cnt_r <= cnt_r - 15'd1;
        err_r <= err_nxt;
      end
      if (cmd.commit && !err_r) begin
        held_year_r  <= wy_r;
        held_month_r <= wm_r;
        held_day_r   <= wd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r <= in_op;
      n_r  <= in_step_count;
      ly_r <= in_load_year;
      lm_r <= in_load_month;
      ld_r <= in_load_day;
      wy_r <= held_year_r;
      wm_r <= held_month_r;
      wd_r <= held_day_r;
    end else if (cmd.step && !sts.done) begin
      wy_r <= wy_nxt;
      wm_r <= wm_nxt;
      wd_r <= wd_nxt;
    end
    if (cmd.wday) begin
      q_r <= div100(yy);
    end
    if (cmd.emit) begin
      o_year_r  <= held_year_r;
      o_month_r <= held_month_r;
      o_day_r   <= held_day_r;
      o_wday_r  <= mod7(wsum);
      o_err_r   <= err_r;
    end
  end

  assign out_cur_year    = o_year_r;
  assign out_cur_month   = o_month_r;
  assign out_cur_day     = o_day_r;
  assign out_weekday     = o_wday_r;
  assign out_range_error = o_err_r;

endmodule

// ===== bench/date_checker.sv =====
// Checker for the calendar date stepper: watches both channels, predicts each
// result from its own copy of the held date and compares it field by field.
// Depends on cds_pkg for the opcode enum.
`timescale 1ns / 1ps

module date_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [14:0] in_step_count,
  input  logic [13:0] in_load_year,
  input  logic [3:0]  in_load_month,
  input  logic [4:0]  in_load_day,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [13:0] out_cur_year,
  input  logic [3:0]  out_cur_month,
  input  logic [4:0]  out_cur_day,
  input  logic [2:0]  out_weekday,
  input  logic        out_range_error,
  output int          fails,
  output int          pending
);
  import cds_pkg::*;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  wday;
    logic        refused;
  } date_result_t;

  localparam int unsigned FIRST_YEAR = 1;
  localparam int unsigned LAST_YEAR  = 9999;
  localparam int          REPORT_MAX = 10;

  int unsigned  date_year;
  int unsigned  date_month;
  int unsigned  date_day;
  date_result_t expected_dates[$];

  function automatic bit leap_year(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned days_in(int unsigned y, int unsigned m);
    int unsigned len;
    case (m)
      2: begin
        len = leap_year(y) ? 29 : 28;
      end
      4, 6, 9, 11: begin
        len = 30;
      end
      default: begin
        len = 31;
      end
    endcase
    return len;
  endfunction

  // Shift Jan/Feb into the previous year so the leap day ends the year
  function automatic int unsigned day_of_week(int unsigned y, int unsigned m, int unsigned d);
    int unsigned a;
    int unsigned yy;
    int unsigned mm;
    a  = (14 - m) / 12;
    yy = y - a;
    mm = m + 12 * a - 2;
    return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
  endfunction

  // Apply one command to the held date and return the result it reports
  function automatic date_result_t step_calendar(op_t op, int unsigned n, int unsigned ly,
                                                 int unsigned lm, int unsigned ld);
    int unsigned  y;
    int unsigned  m;
    int unsigned  d;
    bit           refused;
    date_result_t r;
    y       = date_year;
    m       = date_month;
    d       = date_day;
    refused = 1'b0;
    case (op)
      OP_LOAD: begin
        if (ly < FIRST_YEAR || ly > LAST_YEAR) begin
          refused = 1'b1;
        end else begin
          if (lm < 1) lm = 1;
          if (lm > 12) lm = 12;
          if (ld < 1) ld = 1;
          if (ld > days_in(ly, lm)) ld = days_in(ly, lm);
          y = ly;
          m = lm;
          d = ld;
        end
      end
      OP_ADD_DAYS: begin
        for (int i = 0; i < n && !refused; i++) begin
          if (d >= days_in(y, m)) begin
            d = 1;
            if (m == 12) begin
              if (y >= LAST_YEAR) begin
                refused = 1'b1;
              end else begin
                m = 1;
                y++;
              end
            end else begin
              m++;
            end
          end else begin
            d++;
          end
        end
      end
      OP_SUB_DAYS: begin
        for (int i = 0; i < n && !refused; i++) begin
          if (d <= 1) begin
            if (m == 1) begin
              if (y <= FIRST_YEAR) begin
                refused = 1'b1;
                break;
              end
              y--;
              m = 12;
            end else begin
              m--;
            end
            d = days_in(y, m);
          end else begin
            d--;
          end
        end
      end
      OP_ADD_MONTHS: begin
        for (int i = 0; i < n && !refused; i++) begin
          if (m == 12) begin
            if (y >= LAST_YEAR) begin
              refused = 1'b1;
              break;
            end
            m = 1;
            y++;
          end else begin
            m++;
          end
          if (d > days_in(y, m)) d = days_in(y, m);
        end
      end
      OP_SUB_MONTHS: begin
        for (int i = 0; i < n && !refused; i++) begin
          if (m == 1) begin
            if (y <= FIRST_YEAR) begin
              refused = 1'b1;
              break;
            end
            m = 12;
            y--;
          end else begin
            m--;
          end
          if (d > days_in(y, m)) d = days_in(y, m);
        end
      end
      OP_ADD_YEARS: begin
        if (y + n > LAST_YEAR) begin
          refused = 1'b1;
        end else begin
          y = y + n;
          if (d > days_in(y, m)) d = days_in(y, m);
        end
      end
      OP_SUB_YEARS: begin
        if (n >= y) begin
          refused = 1'b1;
        end else begin
          y = y - n;
          if (d > days_in(y, m)) d = days_in(y, m);
        end
      end
      default: begin
      end
    endcase
    // A refused command leaves the held date alone
    if (!refused) begin
      date_year  = y;
      date_month = m;
      date_day   = d;
    end
    r.year    = 14'(date_year);
    r.month   = 4'(date_month);
    r.day     = 5'(date_day);
    r.wday    = 3'(day_of_week(date_year, date_month, date_day));
    r.refused = refused;
    return r;
  endfunction

  always @(posedge clk) begin
    date_result_t want;
    date_result_t got;
    if (!rst_n) begin
      date_year  = 2000;
      date_month = 1;
      date_day   = 1;
      expected_dates.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_cur_year, out_cur_month, out_cur_day, out_weekday, out_range_error};
        if (expected_dates.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX) begin
            $display("%0t: unexpected result %0d-%0d-%0d wd %0d err %0d", $realtime,
                     got.year, got.month, got.day, got.wday, got.refused);
          end
        end else begin
          want = expected_dates.pop_front();
          if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
              got.wday !== want.wday || got.refused !== want.refused) begin
            fails++;
            if (fails <= REPORT_MAX) begin
              $display("%0t: expected %0d-%0d-%0d wd %0d err %0d, got %0d-%0d-%0d wd %0d err %0d",
                       $realtime, want.year, want.month, want.day, want.wday, want.refused,
                       got.year, got.month, got.day, got.wday, got.refused);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_dates.push_back(step_calendar(op_t'(in_opcode), in_step_count, in_load_year,
                                               in_load_month, in_load_day));
      end
    end
    pending = expected_dates.size();
  end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the calendar date stepper: clock, reset, command stimulus
// and result-side stalls; date_checker does the prediction and comparison.
// Depends on cds_pkg, calendar_date_stepper and date_checker.
`timescale 1ns / 1ps

module tb;
  import cds_pkg::*;

  localparam int PHASE_ITEMS = 170;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 16;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_opcode;
  logic [14:0] in_step_count;
  logic [13:0] in_load_year;
  logic [3:0]  in_load_month;
  logic [4:0]  in_load_day;
  logic        out_valid;
  logic        out_stall;
  logic [13:0] out_cur_year;
  logic [3:0]  out_cur_month;
  logic [4:0]  out_cur_day;
  logic [2:0]  out_weekday;
  logic        out_range_error;
  int          fails;
  int          pending;
  bit          no_idle;
  int          hold_req;

  calendar_date_stepper i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_step_count   (in_step_count),
    .in_load_year    (in_load_year),
    .in_load_month   (in_load_month),
    .in_load_day     (in_load_day),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cur_year    (out_cur_year),
    .out_cur_month   (out_cur_month),
    .out_cur_day     (out_cur_day),
    .out_weekday     (out_weekday),
    .out_range_error (out_range_error)
  );

  date_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_step_count   (in_step_count),
    .in_load_year    (in_load_year),
    .in_load_month   (in_load_month),
    .in_load_day     (in_load_day),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cur_year    (out_cur_year),
    .out_cur_month   (out_cur_month),
    .out_cur_day     (out_cur_day),
    .out_weekday     (out_weekday),
    .out_range_error (out_range_error),
    .fails           (fails),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Enter and leave at a falling edge; valid stays high on exit until a random gap drops it
  task automatic send_cmd(input op_t op, input logic [14:0] n, input logic [13:0] ly,
                          input logic [3:0] lm, input logic [4:0] ld);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_opcode     <= op;
    in_step_count <= n;
    in_load_year  <= ly;
    in_load_month <= lm;
    in_load_day   <= ld;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and hold until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  task automatic send_random();
    op_t         op;
    logic [14:0] n;
    logic [13:0] ly;
    logic [3:0]  lm;
    logic [4:0]  ld;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) op = OP_LOAD;
    else if (pick < 28) op = OP_ADD_DAYS;
    else if (pick < 41) op = OP_SUB_DAYS;
    else if (pick < 52) op = OP_ADD_MONTHS;
    else if (pick < 63) op = OP_SUB_MONTHS;
    else if (pick < 76) op = OP_ADD_YEARS;
    else if (pick < 89) op = OP_SUB_YEARS;
    else op = OP_QUERY;
    // Keep day and month walks short; a rare one runs the full count
    pick = $urandom_range(0, 149);
    if (pick == 0) n = 15'($urandom_range(0, 32767));
    else if (pick < 15) n = 15'($urandom_range(0, 1500));
    else n = 15'($urandom_range(0, 45));
    if (op == OP_ADD_YEARS || op == OP_SUB_YEARS) begin
      n = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 32767))
                                      : 15'($urandom_range(0, 3000));
    end
    // Bias loads toward the ends of the year range
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      ly = 14'($urandom);
      lm = 4'($urandom);
      ld = 5'($urandom);
    end else begin
      if (pick < 4) ly = 14'($urandom_range(1, 3));
      else if (pick < 7) ly = 14'($urandom_range(9997, 9999));
      else ly = 14'($urandom_range(1, 9999));
      lm = 4'($urandom_range(1, 12));
      ld = 5'($urandom_range(1, 31));
    end
    send_cmd(op, n, ly, lm, ld);
  endtask

  // Result side: random stall per result, or a long hold when requested
  initial begin
    int k;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req > 0) begin
        k        = hold_req;
        hold_req = 0;
      end else begin
        k = no_idle ? 0 : $urandom_range(0, 8);
      end
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    no_idle       = 1'b0;
    hold_req      = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = OP_QUERY;
    in_step_count = '0;
    in_load_year  = '0;
    in_load_month = '0;
    in_load_day   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset date, range edges, load clamping, leap day, long walk
    send_cmd(OP_QUERY,      15'd0,     14'd0,     4'd0,  5'd0);
    send_cmd(OP_LOAD,       15'd0,     14'd9999,  4'd12, 5'd31);
    send_cmd(OP_ADD_DAYS,   15'd1,     14'd0,     4'd0,  5'd0);
    send_cmd(OP_ADD_MONTHS, 15'd1,     14'd0,     4'd0,  5'd0);
    send_cmd(OP_ADD_YEARS,  15'd0,     14'd0,     4'd0,  5'd0);
    send_cmd(OP_LOAD,       15'd0,     14'd1,     4'd1,  5'd1);
    send_cmd(OP_SUB_DAYS,   15'd1,     14'd0,     4'd0,  5'd0);
    send_cmd(OP_SUB_MONTHS, 15'd1,     14'd0,     4'd0,  5'd0);
    send_cmd(OP_SUB_YEARS,  15'd1,     14'd0,     4'd0,  5'd0);
    send_cmd(OP_LOAD,       15'd0,     14'd0,     4'd6,  5'd15);
    send_cmd(OP_LOAD,       15'd0,     14'd16383, 4'd15, 5'd31);
    send_cmd(OP_LOAD,       15'd0,     14'd2024,  4'd0,  5'd0);
    send_cmd(OP_LOAD,       15'd0,     14'd2023,  4'd15, 5'd31);
    send_cmd(OP_LOAD,       15'd0,     14'd2023,  4'd2,  5'd31);
    send_cmd(OP_LOAD,       15'd0,     14'd2024,  4'd2,  5'd29);
    send_cmd(OP_ADD_YEARS,  15'd1,     14'd0,     4'd0,  5'd0);
    send_cmd(OP_LOAD,       15'd0,     14'd2000,  4'd1,  5'd31);
    send_cmd(OP_ADD_MONTHS, 15'd1,     14'd0,     4'd0,  5'd0);
    send_cmd(OP_SUB_YEARS,  15'd32767, 14'd0,     4'd0,  5'd0);
    send_cmd(OP_ADD_YEARS,  15'd32767, 14'd0,     4'd0,  5'd0);
    send_cmd(OP_LOAD,       15'd0,     14'd1999,  4'd12, 5'd31);
    send_cmd(OP_ADD_DAYS,   15'd1,     14'd0,     4'd0,  5'd0);
    send_cmd(OP_SUB_DAYS,   15'd1,     14'd0,     4'd0,  5'd0);
    send_cmd(OP_ADD_DAYS,   15'd32767, 14'd0,     4'd0,  5'd0);
    send_cmd(OP_SUB_MONTHS, 15'd13,    14'd0,     4'd0,  5'd0);
    send_cmd(OP_QUERY,      15'd32767, 14'd16383, 4'd15, 5'd31);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 2) hold_req = LONG_HOLD;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Run a stretch back to back with no idling on either side
        no_idle = (phase == 1) && (i < 50);
        send_random();
      end
      no_idle = 1'b0;
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    if (fails == 0) begin
      $display("PASS calendar_date_stepper");
    end else begin
      $display("FAIL calendar_date_stepper");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL calendar_date_stepper");
    $finish;
  end

endmodule
